// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg
// codes, field widths and the control store of the array list engine
// ----------------------------------------------------------------------------
package ale_pkg;

	localparam int DEPTH_DEF = 8;

	localparam int OP_W   = 4;
	localparam int POS_W  = 4;
	localparam int DATA_W = 32;
	localparam int AMT_W  = 31;
	localparam int ST_W   = 3;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 3;
	localparam int BIT_W  = $clog2(AMT_W);
	localparam int UPC_W  = 5;

	// request codes
	localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd1;
	localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
	localparam logic [OP_W-1:0] OP_DEL_BACK  = 4'd4;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd5;
	localparam logic [OP_W-1:0] OP_SEARCH    = 4'd6;
	localparam logic [OP_W-1:0] OP_ROTATE    = 4'd7;
	localparam logic [OP_W-1:0] OP_DUMP      = 4'd8;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_PTR_EQ_POS,
		C_PTR1_EQ_FILL,
		C_PTR1_NE_FILL,
		C_PTR_EQ_FILL,
		C_MATCH,
		C_BIT_MORE,
		C_REM_ZERO
	} cond_t;

	typedef enum logic [1:0] {
		IDX_PTR,
		IDX_PTR_M1,
		IDX_PTR_P1
	} rd_idx_t;

	typedef enum logic [1:0] {
		P_HOLD,
		P_INC,
		P_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		F_HOLD,
		F_INC,
		F_DEC
	} fill_op_t;

	typedef enum logic [1:0] {
		E_NONE,
		E_STATUS,
		E_ELEM
	} emit_t;

	// one control word
	typedef struct packed {
		cond_t              cond;
		logic [UPC_W-1:0]   target;
		logic               rd_en;
		rd_idx_t            rd_idx;
		logic               wr_en;
		logic               wr_rem;    // write index from the rotate pointer
		logic               wr_other;  // write into the spare bank
		logic               wr_val;    // write the request value, else read data
		ptr_op_t            ptr_op;
		fill_op_t           fill_op;
		logic               mod_step;
		logic               rem_adv;
		logic               bank_flip;
		logic               set_ok;
		emit_t              emit;
		logic               done;
	} cw_t;

	// program entry points and steps
	localparam logic [UPC_W-1:0] U_EMIT    = 5'd0;
	localparam logic [UPC_W-1:0] U_INS     = 5'd1;
	localparam logic [UPC_W-1:0] U_INS_MV  = 5'd2;
	localparam logic [UPC_W-1:0] U_INS_PUT = 5'd3;
	localparam logic [UPC_W-1:0] U_DEL     = 5'd4;
	localparam logic [UPC_W-1:0] U_DEL_MV  = 5'd5;
	localparam logic [UPC_W-1:0] U_DEL_END = 5'd6;
	localparam logic [UPC_W-1:0] U_SRCH    = 5'd7;
	localparam logic [UPC_W-1:0] U_SRCH_CMP = 5'd8;
	localparam logic [UPC_W-1:0] U_SRCH_NXT = 5'd9;
	localparam logic [UPC_W-1:0] U_SRCH_HIT = 5'd10;
	localparam logic [UPC_W-1:0] U_MOD     = 5'd11;
	localparam logic [UPC_W-1:0] U_ROT     = 5'd12;
	localparam logic [UPC_W-1:0] U_ROT_RD  = 5'd13;
	localparam logic [UPC_W-1:0] U_ROT_WR  = 5'd14;
	localparam logic [UPC_W-1:0] U_ROT_END = 5'd15;
	localparam logic [UPC_W-1:0] U_DUMP    = 5'd16;
	localparam logic [UPC_W-1:0] U_DUMP_OUT = 5'd17;

	function automatic cw_t ucode(input logic [UPC_W-1:0] upc);
		cw_t w;
		w = '0;
		case (upc)
			U_INS: begin
				w.cond   = C_PTR_EQ_POS;
				w.target = U_INS_PUT;
				w.rd_en  = 1'b1;
				w.rd_idx = IDX_PTR_M1;
			end
			U_INS_MV: begin
				w.wr_en  = 1'b1;
				w.ptr_op = P_DEC;
				w.cond   = C_ALWAYS;
				w.target = U_INS;
			end
			U_INS_PUT: begin
				w.wr_en   = 1'b1;
				w.wr_val  = 1'b1;
				w.fill_op = F_INC;
				w.cond    = C_ALWAYS;
				w.target  = U_EMIT;
			end
			U_DEL: begin
				w.cond   = C_PTR1_EQ_FILL;
				w.target = U_DEL_END;
				w.rd_en  = 1'b1;
				w.rd_idx = IDX_PTR_P1;
			end
			U_DEL_MV: begin
				w.wr_en  = 1'b1;
				w.ptr_op = P_INC;
				w.cond   = C_ALWAYS;
				w.target = U_DEL;
			end
			U_DEL_END: begin
				w.fill_op = F_DEC;
				w.cond    = C_ALWAYS;
				w.target  = U_EMIT;
			end
			U_SRCH: begin
				w.cond   = C_PTR_EQ_FILL;
				w.target = U_EMIT;
				w.rd_en  = 1'b1;
				w.rd_idx = IDX_PTR;
			end
			U_SRCH_CMP: begin
				w.cond   = C_MATCH;
				w.target = U_SRCH_HIT;
			end
			U_SRCH_NXT: begin
				w.ptr_op = P_INC;
				w.cond   = C_ALWAYS;
				w.target = U_SRCH;
			end
			U_SRCH_HIT: begin
				w.set_ok = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = U_EMIT;
			end
			U_MOD: begin
				w.mod_step = 1'b1;
				w.cond     = C_BIT_MORE;
				w.target   = U_MOD;
			end
			U_ROT: begin
				w.cond   = C_REM_ZERO;
				w.target = U_EMIT;
			end
			U_ROT_RD: begin
				w.cond   = C_PTR_EQ_FILL;
				w.target = U_ROT_END;
				w.rd_en  = 1'b1;
				w.rd_idx = IDX_PTR;
			end
			U_ROT_WR: begin
				w.wr_en    = 1'b1;
				w.wr_rem   = 1'b1;
				w.wr_other = 1'b1;
				w.ptr_op   = P_INC;
				w.rem_adv  = 1'b1;
				w.cond     = C_ALWAYS;
				w.target   = U_ROT_RD;
			end
			U_ROT_END: begin
				w.bank_flip = 1'b1;
				w.cond      = C_ALWAYS;
				w.target    = U_EMIT;
			end
			U_DUMP: begin
				w.rd_en  = 1'b1;
				w.rd_idx = IDX_PTR;
			end
			U_DUMP_OUT: begin
				w.emit   = E_ELEM;
				w.ptr_op = P_INC;
				w.cond   = C_PTR1_NE_FILL;
				w.target = U_DUMP;
				w.done   = 1'b1;
			end
			default: begin
				// status result and back to idle
				w.emit = E_STATUS;
				w.done = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/ale_ram.sv =====
// ----------------------------------------------------------------------------
// ale_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/array_list_engine.sv =====
// ----------------------------------------------------------------------------
// array_list_engine
// packed list of signed 32-bit words run by a small microcoded sequencer:
// insert, delete, search, rotate right and dump, one request at a time
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  request   start && !busy       op, position, data_value, rotate_amount
//  result    valid (one cycle)    status, entry_count, found_index, element,
//                                 last
//
// sequence per request, while busy:
//   insert and delete move the entries above the position, search scans the list,
//   rotate does a bit-serial modulo of the amount, then a copy pass; dump reads all
//   errors and trivial cases go straight to the status step
// the loop bound is the single read port of the list ram: each entry move is
// a read, then a write of the registered read data
// reset clears the entry count and the bank select; ram contents need none
// results cannot be stalled; the next request is taken as soon as busy drops,
// while the last result beat is still on the result ports
`include "assert_macros.svh"

module array_list_engine #(
	parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ale_pkg::OP_W-1:0]        op,
	input  logic [ale_pkg::POS_W-1:0]       position,
	input  logic signed [ale_pkg::DATA_W-1:0] data_value,
	input  logic [ale_pkg::AMT_W-1:0]       rotate_amount,
	output logic                            valid,
	output logic [ale_pkg::ST_W-1:0]        status,
	output logic [ale_pkg::CNT_W-1:0]       entry_count,
	output logic [ale_pkg::IDX_W-1:0]       found_index,
	output logic signed [ale_pkg::DATA_W-1:0] element,
	output logic                            last
);

	localparam int CW        = $clog2(DEPTH + 1);   // count and pointer width
	localparam int IW        = $clog2(DEPTH);       // entry index width
	localparam int RAM_DEPTH = 2 * (1 << IW);       // two banks for rotate
	localparam int AW        = IW + 1;
	localparam int XW        = CW + ale_pkg::POS_W;
	localparam logic [CW-1:0] FILL_MAX = CW'(DEPTH);

	// sequencer state
	logic                        busy_q;
	logic [ale_pkg::UPC_W-1:0]   upc_q;
	ale_pkg::cw_t                cw;
	logic                        take;
	logic                        accept;

	// list state
	logic [CW-1:0]               fill_q;
	logic                        bank_q;

	// per-request datapath registers
	logic [CW-1:0]               ptr_q;
	logic [CW-1:0]               pos_q;
	logic [ale_pkg::ST_W-1:0]    status_q;
	logic                        srch_q;
	logic [ale_pkg::DATA_W-1:0]  val_q;
	logic [ale_pkg::AMT_W-1:0]   amt_q;
	logic [ale_pkg::BIT_W-1:0]   bitcnt_q;
	logic [CW-1:0]               rem_q;

	// result registers
	logic                        valid_q;
	logic [ale_pkg::ST_W-1:0]    res_status_q;
	logic [ale_pkg::CNT_W-1:0]   res_count_q;
	logic [ale_pkg::IDX_W-1:0]   res_found_q;
	logic [ale_pkg::DATA_W-1:0]  res_elem_q;
	logic                        res_last_q;

	// request decode
	logic [ale_pkg::UPC_W-1:0]   d_upc;
	logic [ale_pkg::ST_W-1:0]    d_status;
	logic [CW-1:0]               d_pos;
	logic [CW-1:0]               d_ptr;
	logic                        d_srch;
	logic [XW-1:0]               pos_x;
	logic [XW-1:0]               fill_x;
	logic [XW-1:0]               tgt_x;

	// datapath arithmetic
	logic [CW:0]                 fill_w;
	logic [CW:0]                 ptr_p1;
	logic [CW-1:0]               ptr_m1;
	logic [CW:0]                 trial;
	logic [CW-1:0]               mod_next;
	logic [CW:0]                 rem_p1;
	logic [CW-1:0]               rem_wrap;

	// ram ports
	logic                        ram_wr_en;
	logic [AW-1:0]               ram_wr_addr;
	logic [ale_pkg::DATA_W-1:0]  ram_wr_data;
	logic                        ram_rd_en;
	logic [AW-1:0]               ram_rd_addr;
	logic [ale_pkg::DATA_W-1:0]  ram_rd_data;
	logic [IW-1:0]               rd_idx;
	logic [IW-1:0]               wr_idx;

	assign accept = start && !busy_q;
	assign cw     = ale_pkg::ucode(upc_q);

	// ------------------------------------------------------------------
	// request decode: error checks, normalized position and entry point
	// ------------------------------------------------------------------
	always_comb begin
		d_upc    = ale_pkg::U_EMIT;
		d_status = ale_pkg::ST_OK;
		d_pos    = '0;
		d_ptr    = '0;
		d_srch   = 1'b0;
		pos_x    = XW'(position);
		fill_x   = XW'(fill_q);
		tgt_x    = pos_x;
		case (op)
			ale_pkg::OP_INS_FRONT, ale_pkg::OP_INS_BACK, ale_pkg::OP_INS_AT: begin
				if (op == ale_pkg::OP_INS_FRONT) begin
					tgt_x = '0;
				end else if (op == ale_pkg::OP_INS_BACK) begin
					tgt_x = fill_x;
				end
				if (fill_q >= FILL_MAX) begin
					d_status = ale_pkg::ST_FULL;
				end else if (tgt_x > fill_x) begin
					d_status = ale_pkg::ST_BADPOS;
				end else begin
					// shift down from the top toward the insert slot
					d_upc = ale_pkg::U_INS;
					d_pos = CW'(tgt_x);
					d_ptr = fill_q;
				end
			end
			ale_pkg::OP_DEL_FRONT, ale_pkg::OP_DEL_BACK, ale_pkg::OP_DEL_AT: begin
				if (op == ale_pkg::OP_DEL_FRONT) begin
					tgt_x = '0;
				end else if (op == ale_pkg::OP_DEL_BACK) begin
					tgt_x = fill_x - XW'(1);
				end
				if (fill_q == '0) begin
					d_status = ale_pkg::ST_EMPTY;
				end else if (tgt_x >= fill_x) begin
					d_status = ale_pkg::ST_BADPOS;
				end else begin
					// close the gap upward from the deleted slot
					d_upc = ale_pkg::U_DEL;
					d_pos = CW'(tgt_x);
					d_ptr = CW'(tgt_x);
				end
			end
			ale_pkg::OP_SEARCH: begin
				// a miss falls out of the scan with this status
				d_status = ale_pkg::ST_NOTFOUND;
				d_upc    = ale_pkg::U_SRCH;
				d_srch   = 1'b1;
			end
			ale_pkg::OP_ROTATE: begin
				// nothing to rotate on an empty list
				if (fill_q != '0) begin
					d_upc = ale_pkg::U_MOD;
				end
			end
			ale_pkg::OP_DUMP: begin
				if (fill_q == '0) begin
					d_status = ale_pkg::ST_EMPTY;
				end else begin
					d_upc = ale_pkg::U_DUMP;
				end
			end
			default: begin
				d_status = ale_pkg::ST_BADPOS;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// datapath arithmetic
	// ------------------------------------------------------------------
	assign fill_w = {1'b0, fill_q};
	assign ptr_p1 = {1'b0, ptr_q} + (CW + 1)'(1);
	assign ptr_m1 = ptr_q - CW'(1);

	// one restoring step of amount modulo count, msb of the amount first
	assign trial    = {rem_q, amt_q[ale_pkg::AMT_W-1]};
	assign mod_next = (trial >= fill_w) ? CW'(trial - fill_w) : CW'(trial);

	// rotate destination pointer wraps at the count
	assign rem_p1   = {1'b0, rem_q} + (CW + 1)'(1);
	assign rem_wrap = (rem_p1 == fill_w) ? '0 : CW'(rem_p1);

	// jump condition
	always_comb begin
		case (cw.cond)
			ale_pkg::C_NEVER:        take = 1'b0;
			ale_pkg::C_ALWAYS:       take = 1'b1;
			ale_pkg::C_PTR_EQ_POS:   take = (ptr_q == pos_q);
			ale_pkg::C_PTR1_EQ_FILL: take = (ptr_p1 == fill_w);
			ale_pkg::C_PTR1_NE_FILL: take = (ptr_p1 != fill_w);
			ale_pkg::C_PTR_EQ_FILL:  take = (ptr_q == fill_q);
			ale_pkg::C_MATCH:        take = (ram_rd_data == val_q);
			ale_pkg::C_BIT_MORE:     take = (bitcnt_q != '0);
			ale_pkg::C_REM_ZERO:     take = (rem_q == '0);
			default:                 take = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------
	// list ram: the live bank is picked by bank_q, rotate fills the other
	// ------------------------------------------------------------------
	always_comb begin
		case (cw.rd_idx)
			ale_pkg::IDX_PTR_M1: rd_idx = IW'(ptr_m1);
			ale_pkg::IDX_PTR_P1: rd_idx = IW'(ptr_p1);
			default:             rd_idx = IW'(ptr_q);
		endcase
	end

	assign wr_idx      = cw.wr_rem ? IW'(rem_q) : IW'(ptr_q);
	assign ram_rd_en   = busy_q && cw.rd_en;
	assign ram_rd_addr = {bank_q, rd_idx};
	assign ram_wr_en   = busy_q && cw.wr_en;
	assign ram_wr_addr = {bank_q ^ cw.wr_other, wr_idx};
	assign ram_wr_data = cw.wr_val ? val_q : ram_rd_data;

	ale_ram #(
		.WIDTH (ale_pkg::DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_list_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// ------------------------------------------------------------------
	// sequencer, list state and result strobe
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			upc_q   <= ale_pkg::U_EMIT;
			valid_q <= 1'b0;
			fill_q  <= '0;
			bank_q  <= 1'b0;
		end else begin
			valid_q <= busy_q && (cw.emit != ale_pkg::E_NONE);
			if (accept) begin
				busy_q <= 1'b1;
				upc_q  <= d_upc;
			end else if (busy_q) begin
				if (take) begin
					upc_q <= cw.target;
				end else if (cw.done) begin
					busy_q <= 1'b0;
				end else begin
					upc_q <= upc_q + ale_pkg::UPC_W'(1);
				end
				case (cw.fill_op)
					ale_pkg::F_INC: fill_q <= fill_q + CW'(1);
					ale_pkg::F_DEC: fill_q <= fill_q - CW'(1);
					default:        fill_q <= fill_q;
				endcase
				if (cw.bank_flip) begin
					bank_q <= !bank_q;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// per-request registers and result payload
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			ptr_q    <= d_ptr;
			pos_q    <= d_pos;
			status_q <= d_status;
			srch_q   <= d_srch;
			val_q    <= data_value;
			amt_q    <= rotate_amount;
			bitcnt_q <= ale_pkg::BIT_W'(ale_pkg::AMT_W - 1);
			rem_q    <= '0;
		end else if (busy_q) begin
			case (cw.ptr_op)
				ale_pkg::P_INC: ptr_q <= CW'(ptr_p1);
				ale_pkg::P_DEC: ptr_q <= ptr_m1;
				default:        ptr_q <= ptr_q;
			endcase
			if (cw.mod_step) begin
				rem_q    <= mod_next;
				amt_q    <= amt_q << 1;
				bitcnt_q <= bitcnt_q - ale_pkg::BIT_W'(1);
			end else if (cw.rem_adv) begin
				rem_q <= rem_wrap;
			end
			if (cw.set_ok) begin
				status_q <= ale_pkg::ST_OK;
			end
		end

		if (busy_q) begin
			case (cw.emit)
				ale_pkg::E_STATUS: begin
					res_status_q <= status_q;
					res_count_q  <= ale_pkg::CNT_W'(fill_q);
					// index only for a search hit, ptr stays on the match
					res_found_q  <= (srch_q && (status_q == ale_pkg::ST_OK)) ?
						ale_pkg::IDX_W'(ptr_q) : '0;
					res_elem_q   <= '0;
					res_last_q   <= 1'b1;
				end
				ale_pkg::E_ELEM: begin
					res_status_q <= ale_pkg::ST_OK;
					res_count_q  <= ale_pkg::CNT_W'(fill_q);
					res_found_q  <= '0;
					res_elem_q   <= ram_rd_data;
					res_last_q   <= (ptr_p1 == fill_w);
				end
				default: begin
					res_status_q <= res_status_q;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign valid       = valid_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;
	assign found_index = res_found_q;
	assign element     = $signed(res_elem_q);
	assign last        = res_last_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`ASSERT_ALWAYS(a_fill_range, clk, arst_n, fill_q <= FILL_MAX, "entry count above depth")
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy_q, "accepted request not running")
	`ASSERT_IMPLIES(a_last_idle, clk, arst_n, valid_q && res_last_q, !busy_q,
		"sequencer still busy on final beat")
	`ASSERT_IMPLIES(a_beat_busy, clk, arst_n, valid_q, $past(busy_q),
		"result beat without a running request")
	`ASSERT_IMPLIES(a_found_ok, clk, arst_n,
		valid_q && (res_status_q != ale_pkg::ST_OK), res_found_q == '0,
		"found index set on a failed request")

endmodule
